// ----- design/rledc_pkg.sv -----
// Package for the run-length encoder with ASCII decimal counts.
// Holds the channel payload types and the fixed constants used by the queue and back end.
// No dependencies.
package rledc_pkg;

	typedef struct packed {
		logic [7:0] symbol;
		logic       end_of_string;
	} in_t;

	typedef struct packed {
		logic [7:0] out_byte;
		logic       out_last;
	} out_t;

	typedef struct packed {
		logic full;
		logic empty;
	} q_status_t;

	localparam int unsigned QDEPTH     = 4;
	localparam int unsigned QPTR_W     = 2;
	localparam int unsigned QCNT_W     = 3;
	localparam int unsigned DEC_DIGITS = 5;
	localparam int unsigned DEC_BITS   = 17;
	localparam logic [7:0]  ASCII_ZERO = 8'h30;

endpackage

// ----- design/rledc_front.sv -----
// Front end: accepts symbols, tracks the open run and issues run-close commands.
// Depends on rledc_pkg; feeds rledc_fifo.
module rledc_front #(
	parameter int unsigned RUN_BITS = 16
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  in_valid,
	output logic                  in_ready,
	input  rledc_pkg::in_t        in_data,
	input  rledc_pkg::q_status_t  q_status,
	output logic                  push,
	output logic [7:0]            push_sym,
	output logic [RUN_BITS-1:0]   push_len,
	output logic                  push_last
);

	localparam longint unsigned RUN_CAP = (64'd1 << RUN_BITS) - 64'd1;
	localparam longint unsigned RUN_LIMIT = (RUN_CAP < 64'd99999) ? RUN_CAP : 64'd99999;
	localparam logic [RUN_BITS-1:0] LIMIT = RUN_BITS'(RUN_LIMIT);
	localparam logic [RUN_BITS-1:0] ONE = RUN_BITS'(1);

	logic [7:0]          sym_q;
	logic [RUN_BITS-1:0] len_q;
	logic                open_q;
	logic                pend_q;
	logic [7:0]          pend_sym_q;
	logic [RUN_BITS-1:0] pend_len_q;

	logic                accept;
	logic                join_run;
	logic                close_old;
	logic [RUN_BITS-1:0] new_len;

	assign in_ready  = !pend_q && !q_status.full;
	assign accept    = in_valid && in_ready;
	assign join_run  = open_q && (in_data.symbol == sym_q) && (len_q < LIMIT);
	assign close_old = open_q && !join_run;
	assign new_len   = join_run ? len_q + ONE : ONE;

	always_comb begin
		push      = 1'b0;
		push_sym  = sym_q;
		push_len  = len_q;
		push_last = 1'b0;
		if (pend_q) begin
			push      = !q_status.full;
			push_sym  = pend_sym_q;
			push_len  = pend_len_q;
			push_last = 1'b1;
		end else if (accept) begin
			if (close_old) begin
				push = 1'b1;
			end else if (in_data.end_of_string) begin
				push      = 1'b1;
				push_sym  = in_data.symbol;
				push_len  = new_len;
				push_last = 1'b1;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sym_q  <= '0;
			len_q  <= '0;
			open_q <= 1'b0;
			pend_q <= 1'b0;
		end else begin
			if (pend_q && !q_status.full) begin
				pend_q <= 1'b0;
			end
			if (accept) begin
				sym_q <= in_data.symbol;
				if (in_data.end_of_string) begin
					open_q <= 1'b0;
					len_q  <= '0;
					if (close_old) begin
						pend_q <= 1'b1;
					end
				end else begin
					open_q <= 1'b1;
					len_q  <= new_len;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			pend_sym_q <= in_data.symbol;
			pend_len_q <= new_len;
		end
	end

endmodule

// ----- design/rledc_fifo.sv -----
// Command queue between front and back: run symbol, run length, last flag.
// Depends on rledc_pkg; one push and one pop per cycle.
module rledc_fifo #(
	parameter int unsigned RUN_BITS = 16
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  push,
	input  logic [7:0]            push_sym,
	input  logic [RUN_BITS-1:0]   push_len,
	input  logic                  push_last,
	input  logic                  pop,
	output logic [7:0]            pop_sym,
	output logic [RUN_BITS-1:0]   pop_len,
	output logic                  pop_last,
	output rledc_pkg::q_status_t  status
);

	logic [7:0]          sym_mem [rledc_pkg::QDEPTH];
	logic [RUN_BITS-1:0] len_mem [rledc_pkg::QDEPTH];
	logic                last_mem [rledc_pkg::QDEPTH];

	logic [rledc_pkg::QPTR_W-1:0] wr_ptr_q;
	logic [rledc_pkg::QPTR_W-1:0] rd_ptr_q;
	logic [rledc_pkg::QCNT_W-1:0] count_q;

	assign status.full  = (count_q == rledc_pkg::QCNT_W'(rledc_pkg::QDEPTH));
	assign status.empty = (count_q == '0);
	assign pop_sym  = sym_mem[rd_ptr_q];
	assign pop_len  = len_mem[rd_ptr_q];
	assign pop_last = last_mem[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			sym_mem[wr_ptr_q]  <= push_sym;
			len_mem[wr_ptr_q]  <= push_len;
			last_mem[wr_ptr_q] <= push_last;
		end
	end

endmodule

// ----- design/rledc_back.sv -----
// Back end: emits the run symbol and, when the count exceeds one, converts the count to
// BCD bit by bit and streams its decimal digits. Depends on rledc_pkg; reads from rledc_fifo.
module rledc_back #(
	parameter int unsigned RUN_BITS = 16
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  rledc_pkg::q_status_t  q_status,
	input  logic [7:0]            q_sym,
	input  logic [RUN_BITS-1:0]   q_len,
	input  logic                  q_last,
	output logic                  pop,
	output logic                  out_valid,
	input  logic                  out_ready,
	output rledc_pkg::out_t       out_data
);

	localparam int unsigned CNT_W = (RUN_BITS < rledc_pkg::DEC_BITS) ? RUN_BITS
		: rledc_pkg::DEC_BITS;
	localparam int unsigned STEP_W = $clog2(CNT_W + 1);
	localparam int unsigned BCD_W = 4 * rledc_pkg::DEC_DIGITS;

	typedef enum logic [1:0] {
		B_IDLE,
		B_CONV,
		B_DIGIT
	} state_t;

	state_t              state_q;
	logic                ov_q;
	rledc_pkg::out_t     out_q;
	logic [CNT_W-1:0]    bin_q;
	logic [BCD_W-1:0]    bcd_q;
	logic [STEP_W-1:0]   step_q;
	logic [2:0]          idx_q;
	logic                last_q;

	logic                out_free;
	logic                multi;
	logic [BCD_W-1:0]    bcd_adj;
	logic [BCD_W-1:0]    bcd_nx;
	logic [2:0]          top_nx;
	logic [3:0]          digit;

	assign out_valid = ov_q;
	assign out_data  = out_q;
	assign out_free  = !ov_q || out_ready;
	assign multi     = (q_len > RUN_BITS'(1));
	assign pop       = (state_q == B_IDLE) && !q_status.empty && out_free;
	assign digit     = bcd_q[4*idx_q +: 4];

	always_comb begin
		bcd_adj = bcd_q;
		for (int i = 0; i < rledc_pkg::DEC_DIGITS; i++) begin
			if (bcd_q[4*i +: 4] >= 4'd5) begin
				bcd_adj[4*i +: 4] = bcd_q[4*i +: 4] + 4'd3;
			end
		end
		bcd_nx = {bcd_adj[BCD_W-2:0], bin_q[CNT_W-1]};
		top_nx = '0;
		for (int i = 0; i < rledc_pkg::DEC_DIGITS; i++) begin
			if (bcd_nx[4*i +: 4] != 4'd0) begin
				top_nx = 3'(i);
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= B_IDLE;
			ov_q    <= 1'b0;
			step_q  <= '0;
			idx_q   <= '0;
			last_q  <= 1'b0;
		end else begin
			case (state_q)
				B_IDLE: begin
					if (pop) begin
						ov_q   <= 1'b1;
						last_q <= q_last;
						if (multi) begin
							step_q  <= STEP_W'(CNT_W);
							state_q <= B_CONV;
						end
					end else if (out_ready) begin
						ov_q <= 1'b0;
					end
				end
				B_CONV: begin
					if (out_ready) begin
						ov_q <= 1'b0;
					end
					step_q <= step_q - 1'b1;
					if (step_q == STEP_W'(1)) begin
						idx_q   <= top_nx;
						state_q <= B_DIGIT;
					end
				end
				B_DIGIT: begin
					if (out_free) begin
						ov_q <= 1'b1;
						if (idx_q == '0) begin
							state_q <= B_IDLE;
						end else begin
							idx_q <= idx_q - 1'b1;
						end
					end
				end
				default: begin
					if (out_ready) begin
						ov_q <= 1'b0;
					end
					state_q <= B_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			B_IDLE: begin
				if (pop) begin
					out_q.out_byte <= q_sym;
					out_q.out_last <= q_last && !multi;
					bin_q          <= q_len[CNT_W-1:0];
					bcd_q          <= '0;
				end
			end
			B_CONV: begin
				bcd_q <= bcd_nx;
				bin_q <= bin_q << 1;
			end
			B_DIGIT: begin
				if (out_free) begin
					out_q.out_byte <= rledc_pkg::ASCII_ZERO + {4'h0, digit};
					out_q.out_last <= last_q && (idx_q == '0);
				end
			end
			default: begin
			end
		endcase
	end

endmodule

// ----- design/run_length_encoder_decimal_counts_core.sv -----
// Run-length encoder with ASCII decimal counts: top level.
// Throughput: one symbol per cycle while the command queue has room; a symbol that both
// closes a run and ends the string stalls input until its second command is pushed.
// Back end per closed run: the symbol byte, then, when the count exceeds one, a BCD
// conversion of the low min(RUN_BITS,17) count bits and one ASCII byte per digit.
// Reset clears the open run, the command queue and the output valid flag.
module run_length_encoder_decimal_counts_core #(
	parameter int unsigned RUN_BITS = 16
) (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            in_valid,
	output logic            in_ready,
	input  rledc_pkg::in_t  in_data,
	output logic            out_valid,
	input  logic            out_ready,
	output rledc_pkg::out_t out_data
);

	rledc_pkg::q_status_t q_status;
	logic                 push;
	logic [7:0]           push_sym;
	logic [RUN_BITS-1:0]  push_len;
	logic                 push_last;
	logic                 pop;
	logic [7:0]           pop_sym;
	logic [RUN_BITS-1:0]  pop_len;
	logic                 pop_last;

	rledc_front #(.RUN_BITS(RUN_BITS)) u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.in_data   (in_data),
		.q_status  (q_status),
		.push      (push),
		.push_sym  (push_sym),
		.push_len  (push_len),
		.push_last (push_last)
	);

	rledc_fifo #(.RUN_BITS(RUN_BITS)) u_fifo (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_sym  (push_sym),
		.push_len  (push_len),
		.push_last (push_last),
		.pop       (pop),
		.pop_sym   (pop_sym),
		.pop_len   (pop_len),
		.pop_last  (pop_last),
		.status    (q_status)
	);

	rledc_back #(.RUN_BITS(RUN_BITS)) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.q_status  (q_status),
		.q_sym     (pop_sym),
		.q_len     (pop_len),
		.q_last    (pop_last),
		.pop       (pop),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_data  (out_data)
	);

	a_push_not_full: assert property (@(posedge clk) disable iff (!arst_n)
		push |-> !q_status.full) else $error("push into full queue");

	a_pop_not_empty: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> !q_status.empty) else $error("pop from empty queue");

	a_status_excl: assert property (@(posedge clk) disable iff (!arst_n)
		!(q_status.full && q_status.empty)) else $error("queue full and empty");

	a_ready_room: assert property (@(posedge clk) disable iff (!arst_n)
		in_ready |-> !q_status.full) else $error("ready with full queue");

endmodule

// ----- tb/sv/tb_top.sv -----
// Self-checking testbench for run_length_encoder_decimal_counts_core.
// Drives symbol strings through valid/ready with random gaps and stalls, predicts the
// encoded byte stream in-bench and checks every output transaction; needs rledc_pkg.
`timescale 1ns / 100ps

module tb_top;

	localparam int unsigned RUN_BITS  = 16;
	localparam int unsigned RUN_CAP   = (RUN_BITS >= 32) ? 32'hFFFF_FFFF
		: ((32'd1 << RUN_BITS) - 1);
	localparam int unsigned RUN_LIMIT = (RUN_CAP < 99999) ? RUN_CAP : 99999;
	localparam int unsigned RAND_ITEMS = 360;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_ready;
	rledc_pkg::in_t  in_data = '0;
	logic out_valid;
	logic out_ready = 1'b0;
	rledc_pkg::out_t out_data;

	rledc_pkg::in_t  stim_q[$];
	rledc_pkg::out_t encoded_q[$];

	logic [7:0]  cur_sym = '0;
	int unsigned cur_len = 0;
	bit          cur_live = 1'b0;

	bit in_fire = 1'b0;
	bit out_fire = 1'b0;
	bit src_burst = 1'b0;
	bit snk_burst = 1'b0;
	int src_wait = 0;
	int snk_wait = 0;
	int stall;
	int n_items = 0;
	int mismatches = 0;

	run_length_encoder_decimal_counts_core #(
		.RUN_BITS(RUN_BITS)
	) dut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.in_data(in_data),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.out_data(out_data)
	);

	initial begin
		forever #1 clk = ~clk;
	end

	task automatic close_run(input bit last);
		logic [7:0]  bytes_q[$];
		int unsigned v;
		bytes_q.push_back(cur_sym);
		if (cur_len > 1) begin
			v = cur_len;
			while (v != 0) begin
				bytes_q.insert(1, rledc_pkg::ASCII_ZERO + 8'(v % 10));
				v = v / 10;
			end
		end
		foreach (bytes_q[i])
			encoded_q.push_back(rledc_pkg::out_t'{bytes_q[i],
				last && (i == bytes_q.size() - 1)});
	endtask

	task automatic encode_symbol(input rledc_pkg::in_t item);
		if (cur_live && item.symbol == cur_sym && cur_len < RUN_LIMIT) begin
			cur_len++;
		end else begin
			if (cur_live)
				close_run(1'b0);
			cur_sym  = item.symbol;
			cur_len  = 1;
			cur_live = 1'b1;
		end
		if (item.end_of_string) begin
			close_run(1'b1);
			cur_live = 1'b0;
			cur_len  = 0;
		end
	endtask

	// sample both channels
	always @(posedge clk) begin
		in_fire  <= arst_n && in_valid && in_ready;
		out_fire <= arst_n && out_valid && out_ready;
		if (arst_n && in_valid && in_ready)
			encode_symbol(in_data);
		if (arst_n && out_valid && out_ready) begin
			if (encoded_q.size() == 0) begin
				$display("%0t: unexpected output byte %h last %b", $time,
					out_data.out_byte, out_data.out_last);
				mismatches++;
			end else begin
				if (out_data.out_byte !== encoded_q[0].out_byte) begin
					$display("%0t: out_byte expected %h actual %h", $time,
						encoded_q[0].out_byte, out_data.out_byte);
					mismatches++;
				end
				if (out_data.out_last !== encoded_q[0].out_last) begin
					$display("%0t: out_last expected %b actual %b", $time,
						encoded_q[0].out_last, out_data.out_last);
					mismatches++;
				end
				void'(encoded_q.pop_front());
			end
		end
	end

	// input driver: hold until the transaction is taken, then gap, then advance
	always @(negedge clk) begin
		if (!arst_n) begin
			in_valid <= 1'b0;
			src_wait <= 0;
		end else if (!in_valid || in_fire) begin
			if (src_wait > 0) begin
				in_valid <= 1'b0;
				src_wait <= src_wait - 1;
			end else if (stim_q.size() > 0) begin
				in_data  <= stim_q.pop_front();
				in_valid <= 1'b1;
				src_wait <= src_burst ? 0 : int'($urandom_range(0, 12));
			end else begin
				in_valid <= 1'b0;
			end
		end
	end

	// output ready: stall a random count after each transaction
	always @(negedge clk) begin
		if (!arst_n) begin
			out_ready <= 1'b0;
			snk_wait  <= 0;
		end else begin
			stall = out_fire ? (snk_burst ? 0 : int'($urandom_range(0, 12))) : snk_wait;
			if (stall > 0) begin
				out_ready <= 1'b0;
				snk_wait  <= stall - 1;
			end else begin
				out_ready <= 1'b1;
				snk_wait  <= 0;
			end
		end
	end

	task automatic push_item(input logic [7:0] sym, input bit eos);
		stim_q.push_back(rledc_pkg::in_t'{sym, eos});
		n_items++;
	endtask

	task automatic push_run(input logic [7:0] sym, input int len, input bit eos_end);
		for (int i = 0; i < len; i++)
			push_item(sym, eos_end && i == len - 1);
	endtask

	task automatic settle();
		while (stim_q.size() != 0 || in_valid)
			@(posedge clk);
		while (encoded_q.size() != 0)
			@(posedge clk);
	endtask

	function automatic logic [7:0] pick_symbol();
		if ($urandom_range(0, 1) == 0)
			return 8'h61 + 8'($urandom_range(0, 3));
		return 8'($urandom_range(0, 255));
	endfunction

	function automatic int pick_len();
		int r;
		r = $urandom_range(0, 99);
		if (r < 60)
			return $urandom_range(1, 3);
		if (r < 90)
			return $urandom_range(4, 12);
		return $urandom_range(13, 150);
	endfunction

	initial begin
		int base;
		int target;
		int n_runs;
		repeat (4) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// single 8'h00 symbol, count of two on 8'hFF, mixed runs
		push_item(8'h00, 1'b1);
		push_run(8'hFF, 2, 1'b1);
		push_run(8'h41, 3, 1'b0);
		push_run(8'h42, 1, 1'b0);
		push_run(8'h43, 2, 1'b1);
		push_run(8'h55, 10, 1'b1);
		// final symbol differs from the open run
		push_run(8'h01, 2, 1'b0);
		push_item(8'h02, 1'b1);
		settle();

		// long run: three-digit count
		src_burst = 1'b1;
		push_run(8'h37, 123, 1'b1);
		settle();

		base = n_items;
		while (n_items - base < RAND_ITEMS) begin
			src_burst = ($urandom_range(0, 3) == 0);
			snk_burst = ($urandom_range(0, 3) == 0);
			target = n_items + $urandom_range(60, 120);
			while (n_items < target && n_items - base < RAND_ITEMS) begin
				if ($urandom_range(0, 9) == 0) begin
					push_item(8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
				end else begin
					n_runs = $urandom_range(1, 6);
					for (int r = 0; r < n_runs; r++)
						push_run(pick_symbol(), pick_len(),
							r == n_runs - 1 && $urandom_range(0, 9) != 0);
				end
			end
			settle();
		end

		// close any open run
		push_item(pick_symbol(), 1'b1);
		settle();
		repeat (64) @(posedge clk);
		if (mismatches == 0)
			$display("Regression PASS");
		else
			$display("Regression FAIL");
		$finish;
	end

	initial begin
		#1500000;
		$display("Regression FAIL");
		$finish;
	end

endmodule
